// ===== hdl/savf_pkg.sv =====
`timescale 1ns / 1ps

package savf_pkg;

    localparam int PATTERN_LEN  = 8;
    localparam int NUM_CLASSES  = 6;
    localparam int NUM_ROWS     = 7;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int LIMIT_W      = 16;
    localparam int VOTE_W       = 4;
    localparam int CLASS_W      = 3;
    localparam int LEN_W        = 8;

    typedef enum logic [CLASS_W-1:0] {
        CLS_STOP     = 3'd0,
        CLS_FORTY    = 3'd1,
        CLS_SIXTY    = 3'd2,
        CLS_NINETY   = 3'd3,
        CLS_FREE     = 3'd4,
        CLS_NOCHANGE = 3'd5,
        CLS_NONE     = 3'd6
    } class_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LIMIT_FREE     = 3'd0,
        REG_LIMIT_NOCHANGE = 3'd1,
        REG_LIMIT_NINETY   = 3'd2,
        REG_LIMIT_SIXTY    = 3'd3,
        REG_LIMIT_FORTY    = 3'd4,
        REG_LIMIT_HALT     = 3'd5,
        REG_VOTE_CEILING   = 3'd6,
        REG_SWITCH_MARGIN  = 3'd7
    } reg_index_t;

    // Order of the threshold chain, which is also the switching priority.
    localparam class_t CLASS_ORDER [NUM_CLASSES] = '{
        CLS_FREE, CLS_NOCHANGE, CLS_NINETY, CLS_SIXTY, CLS_FORTY, CLS_STOP
    };

    typedef logic [LEN_W-1:0] pulse_len_t;

    localparam pulse_len_t PAT_ROWS [NUM_ROWS][PATTERN_LEN] = '{
        '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
        '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd3, 8'd1, 8'd1},
        '{8'd1, 8'd1, 8'd1, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1},
        '{8'd1, 8'd1, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1},
        '{8'd1, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
        '{8'd1, 8'd3, 8'd1, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1},
        '{8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1}
    };

    localparam class_t PAT_CLASS [NUM_ROWS] = '{
        CLS_NOCHANGE, CLS_STOP, CLS_SIXTY, CLS_FORTY,
        CLS_NINETY, CLS_NOCHANGE, CLS_FREE
    };

    typedef logic [NUM_CLASSES-1:0][LIMIT_W-1:0] limits_t;

    localparam limits_t LIMIT_RESET = {
        16'd600, 16'd500, 16'd400, 16'd300, 16'd200, 16'd100
    };
    localparam logic [VOTE_W-1:0] CEILING_RESET = 4'd10;
    localparam logic [VOTE_W-1:0] MARGIN_RESET  = 4'd2;

    typedef struct packed {
        logic [VOTE_W-1:0] ceiling;
        logic [VOTE_W-1:0] margin;
    } vote_cfg_t;

    typedef struct packed {
        logic               req_type;
        logic [LIMIT_W-1:0] timeout_ticks;
        logic [LEN_W-1:0]   len_a;
        logic [LEN_W-1:0]   len_b;
        logic [LEN_W-1:0]   len_c;
        logic [LEN_W-1:0]   len_d;
        logic [LEN_W-1:0]   len_e;
        logic [LEN_W-1:0]   len_f;
        logic [LEN_W-1:0]   len_g;
        logic [LEN_W-1:0]   len_h;
    } in_item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] aspect;
        logic [CLASS_W-1:0] detected_class;
    } out_item_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        class_t cls;
        logic   vote;
        logic   reeval;
    } cmd_t;

endpackage

// ===== hdl/signal_aspect_vote_filter.sv =====
`timescale 1ns / 1ps

// Signal aspect vote filter. Each input item is a timeout measurement or a
// pattern of eight pulse lengths; the block classifies it, updates six
// saturating vote counters and picks the displayed aspect with hysteresis,
// returning exactly one result item (aspect, detected class) per input item.
// The block sustains one item per clock cycle on both channels while the
// result channel is not stalled. An item accepted at one clock edge passes
// through three registers: the classifier register, captured at that edge,
// then the queue, then the result register. The rate is set by the back
// part, whose counter update and aspect choice are combinational from the
// registered counters, so consecutive items chain through the vote counters
// without a bubble.
// The front part (threshold chain and pattern table) and the back part are
// separated by a short queue of QUEUE_DEPTH items, so a stalled result
// channel does not stop input acceptance until the queue and the
// classifier register have filled. Configuration registers are written
// through the cfg_ port, which is always ready; they are meant to be changed
// only while no item is in flight. Register indexes 0 to 5 are the timeout
// thresholds, tested in that order, 6 is the vote ceiling and 7 is the
// switching margin; the ceiling and margin take the low four data bits.

module signal_aspect_vote_filter import savf_pkg::*; #(
    parameter int QUEUE_DEPTH = savf_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_payload,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    limits_t   limits_reg, limits_next;
    vote_cfg_t vote_cfg_reg, vote_cfg_next;

    // Front to queue, queue to back.
    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic back_valid, back_ready;
    cmd_t back_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        limits_next   = limits_reg;
        vote_cfg_next = vote_cfg_reg;
        if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_LIMIT_FREE:     limits_next[0] = cfg_data;
                REG_LIMIT_NOCHANGE: limits_next[1] = cfg_data;
                REG_LIMIT_NINETY:   limits_next[2] = cfg_data;
                REG_LIMIT_SIXTY:    limits_next[3] = cfg_data;
                REG_LIMIT_FORTY:    limits_next[4] = cfg_data;
                REG_LIMIT_HALT:     limits_next[5] = cfg_data;
                REG_VOTE_CEILING:   vote_cfg_next.ceiling = cfg_data[VOTE_W-1:0];
                REG_SWITCH_MARGIN:  vote_cfg_next.margin  = cfg_data[VOTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg           <= LIMIT_RESET;
            vote_cfg_reg.ceiling <= CEILING_RESET;
            vote_cfg_reg.margin  <= MARGIN_RESET;
        end else begin
            limits_reg   <= limits_next;
            vote_cfg_reg <= vote_cfg_next;
        end
    end

    // The front part classifies each item against the thresholds or the
    // pattern table and registers the resulting command.
    savf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .limits    (limits_reg),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    savf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    // The back part owns the vote counters and the current aspect, and
    // drives the result register.
    savf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .vote_cfg  (vote_cfg_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== hdl/savf_front.sv =====
`timescale 1ns / 1ps

module savf_front import savf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_payload,
    input  limits_t  limits,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_ready
);

    logic       valid_reg, valid_next;
    cmd_t       cmd_reg, cmd_next;
    pulse_len_t lens [PATTERN_LEN];
    class_t     timeout_cls, pattern_cls, cls;
    logic       row_hit [NUM_ROWS];
    logic       accept;

    assign lens[0] = s_payload.len_a;
    assign lens[1] = s_payload.len_b;
    assign lens[2] = s_payload.len_c;
    assign lens[3] = s_payload.len_d;
    assign lens[4] = s_payload.len_e;
    assign lens[5] = s_payload.len_f;
    assign lens[6] = s_payload.len_g;
    assign lens[7] = s_payload.len_h;

    // Both loops walk backward so that the first hit in list order wins.
    always_comb begin
        timeout_cls = CLS_NONE;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (s_payload.timeout_ticks < limits[k]) begin
                timeout_cls = CLASS_ORDER[k];
            end
        end
    end

    always_comb begin
        pattern_cls = CLS_NONE;
        for (int r = 0; r < NUM_ROWS; r++) begin
            row_hit[r] = 1'b1;
            for (int j = 0; j < PATTERN_LEN; j++) begin
                if (lens[j] != PAT_ROWS[r][j]) begin
                    row_hit[r] = 1'b0;
                end
            end
        end
        for (int r = NUM_ROWS - 1; r >= 0; r--) begin
            if (row_hit[r]) begin
                pattern_cls = PAT_CLASS[r];
            end
        end
    end

    assign cls     = s_payload.req_type ? pattern_cls : timeout_cls;
    assign s_ready = !valid_reg || cmd_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd_next   = cmd_reg;
        valid_next = valid_reg;
        if (accept) begin
            valid_next      = 1'b1;
            cmd_next.cls    = cls;
            cmd_next.vote   = (cls != CLS_NONE);
            // A timeout always re-evaluates the aspect; a pattern only on a match.
            cmd_next.reeval = !s_payload.req_type || (cls != CLS_NONE);
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== hdl/savf_fifo.sv =====
`timescale 1ns / 1ps

module savf_fifo import savf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue fill count above its depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill count missed a push");

endmodule

// ===== hdl/savf_back.sv =====
`timescale 1ns / 1ps

module savf_back import savf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    input  vote_cfg_t vote_cfg,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    logic [NUM_CLASSES-1:0][VOTE_W-1:0] counts_reg, counts_next, voted;
    class_t    aspect_reg, aspect_next, cur, pick;
    logic      m_valid_reg, m_valid_next;
    out_item_t out_reg, out_next;
    logic [VOTE_W:0] bar;
    logic      take;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign take      = cmd_valid && cmd_ready;

    // On a vote, the detected class gains a vote up to the ceiling; all others lose one down to zero.
    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            voted[k] = counts_reg[k];
            if (cmd.vote) begin
                if (CLASS_W'(k) == cmd.cls) begin
                    if (counts_reg[k] < vote_cfg.ceiling) begin
                        voted[k] = counts_reg[k] + 1'b1;
                    end
                end else if (counts_reg[k] != '0) begin
                    voted[k] = counts_reg[k] - 1'b1;
                end
            end
        end
    end

    // The first class in priority order that beats the current count plus
    // the margin takes over; the walk goes backward so the first one wins.
    always_comb begin
        cur  = (aspect_reg == CLS_NONE || aspect_reg == class_t'(3'd7)) ?
               CLS_STOP : aspect_reg;
        bar  = {1'b0, voted[cur]} + {1'b0, vote_cfg.margin};
        pick = cur;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (CLASS_ORDER[k] != cur && {1'b0, voted[CLASS_ORDER[k]]} > bar) begin
                pick = CLASS_ORDER[k];
            end
        end
    end

    always_comb begin
        counts_next  = counts_reg;
        aspect_next  = aspect_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (take) begin
            counts_next  = voted;
            aspect_next  = cmd.reeval ? pick : aspect_reg;
            out_next.aspect         = aspect_next;
            out_next.detected_class = cmd.cls;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg  <= '0;
            aspect_reg  <= CLS_STOP;
            m_valid_reg <= 1'b0;
        end else begin
            counts_reg  <= counts_next;
            aspect_reg  <= aspect_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    a_vote_has_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && cmd.vote) |-> (cmd.cls != CLS_NONE && cmd.reeval))
        else $error("vote requested without a detected class");

    a_counts_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !cmd.vote) |=> $stable(counts_reg))
        else $error("vote counters moved on an unclassified item");

    a_aspect_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !cmd.reeval) |=> $stable(aspect_reg))
        else $error("aspect moved on an unmatched pattern");

    a_result_aspect: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> (m_valid && m_payload.aspect == aspect_reg))
        else $error("result aspect differs from stored aspect");

endmodule
